[rtl/lkvc_pkg.sv]
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  // Storage geometry
  localparam int ENTRIES = 16;
  localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 31;
  localparam int RVAL_W = 32;
  localparam int CAP_W  = 5;

  // Stream word widths
  localparam int IN_W  = 64;
  localparam int OUT_W = 72;

  // Configuration port
  localparam int           ADDR_W      = 3;
  localparam int           DATA_W      = 32;
  localparam logic         REG_CAPACITY = 1'b0;   // selected by paddr[2]
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // load the accepted transaction
    logic match;    // register compare and victim results
    logic commit;   // update entries and load the result register
  } cmd_t;

endpackage

[rtl/lkvc_ctrl.sv]
// Controller: sequences accept, match and commit and owns the result valid flag.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   can_commit;

  // Result register is free when empty or being drained this cycle
  assign can_commit = !out_valid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (can_commit) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.match   = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = can_commit;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/lkvc_dp.sv]
// Datapath: entry storage, parallel key compare, victim choice, age update, result register.
module lkvc_dp import lkvc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [IN_W-1:0]  in_data,
  input  logic [CAP_W-1:0] capacity,
  output logic [OUT_W-1:0] out_data
);

  // Captured transaction
  logic             in_mode;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_val;

  // Entry storage
  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [AGE_W-1:0] age     [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   used_count;

  // Match stage results
  logic [ENTRIES-1:0] t_vec;
  logic               t_hit;
  logic               t_evict;
  logic [CNT_W-1:0]   t_limit;
  logic [VAL_W-1:0]   t_value;
  logic [KEY_W-1:0]   t_evkey;

  // Result register
  logic              r_found;
  logic [RVAL_W-1:0] r_value;
  logic              r_evicted;
  logic [KEY_W-1:0]  r_evkey;

  // Combinational match logic
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] old_vec;
  logic [ENTRIES-1:0] inv_vec;
  logic [ENTRIES-1:0] free_vec;
  logic               hit;
  logic               full;
  logic [CNT_W-1:0]   eff_cap;
  logic [CNT_W-1:0]   used_m1;
  logic [AGE_W-1:0]   hit_age;
  logic [VAL_W-1:0]   hit_value;
  logic [KEY_W-1:0]   old_key;

  // Capacity clamped to one..ENTRIES
  always_comb begin
    if (capacity == '0) eff_cap = CNT_W'(1);
    else if (32'(capacity) > 32'(ENTRIES)) eff_cap = CNT_W'(ENTRIES);
    else eff_cap = CNT_W'(capacity);
  end

  assign used_m1 = used_count - CNT_W'(1);
  assign full    = used_count >= eff_cap;

  // Parallel tag compare; the oldest valid entry holds age used_count-1
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    old_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (key_mem[i] == in_key);
      old_vec[i] = valid[i] && (age[i] == used_m1[AGE_W-1:0]);
      hit_age   = hit_age   | (age[i]     & {AGE_W{hit_vec[i]}});
      hit_value = hit_value | (val_mem[i] & {VAL_W{hit_vec[i]}});
      old_key   = old_key   | (key_mem[i] & {KEY_W{old_vec[i]}});
    end
  end

  assign hit      = |hit_vec;
  assign inv_vec  = ~valid;
  assign free_vec = inv_vec & (~inv_vec + ENTRIES'(1));  // lowest free entry

  // Capture and match stage registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode <= in_data[0];
      in_key  <= in_data[KEY_W:1];
      in_val  <= in_data[KEY_W+VAL_W:KEY_W+1];
    end
    if (cmd.match) begin
      t_hit   <= hit;
      t_value <= hit_value;
      t_evkey <= old_key;
      t_evict <= !hit && full && (in_mode == MODE_SET);
      if (hit) begin
        t_vec   <= hit_vec;
        t_limit <= CNT_W'(hit_age);
      end else if (full) begin
        t_vec   <= old_vec;
        t_limit <= used_m1;
      end else begin
        t_vec   <= free_vec;
        t_limit <= used_count;
      end
    end
  end

  // Entry update: target becomes most recent, younger entries age by one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      used_count <= '0;
      for (int i = 0; i < ENTRIES; i++) age[i] <= '0;
    end else if (cmd.commit && (t_hit || in_mode == MODE_SET)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (t_vec[i]) begin
          age[i] <= '0;
          if (in_mode == MODE_SET) valid[i] <= 1'b1;
        end else if (valid[i] && (CNT_W'(age[i]) < t_limit)) begin
          age[i] <= age[i] + AGE_W'(1);
        end
      end
      if (in_mode == MODE_SET && !t_hit && !t_evict) used_count <= used_count + CNT_W'(1);
    end
  end

  // Key and value storage, written only by a set
  always_ff @(posedge clk) begin
    if (cmd.commit && in_mode == MODE_SET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (t_vec[i]) begin
          key_mem[i] <= in_key;
          val_mem[i] <= in_val;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      r_found   <= t_hit;
      r_evicted <= t_evict;
      r_evkey   <= t_evict ? t_evkey : '0;
      if (in_mode == MODE_SET) r_value <= '0;
      else if (t_hit) r_value <= {1'b0, t_value};
      else r_value <= '1;
    end
  end

  assign out_data = {{(OUT_W - 2 - RVAL_W - KEY_W){1'b0}}, r_evkey, r_evicted, r_value, r_found};

endmodule

[rtl/lru_key_value_cache_unit.sv]
// Top level of the LRU key/value cache: stream ports, register port, controller and datapath.
//
//  channel  | direction | contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | mode, key, write_value (one get or set transaction)
//  m_axis   | out       | found, read_value, evicted, evicted_key
//  apb      | in/out    | capacity register at byte address 0
//
// An item passes through accept, registered compare of all sixteen
// tags with victim choice, then the entry and age update.
// The commit waits while a previous result is still held and not taken;
// a new item is accepted while the last result waits at m_axis.
// Reset clears valid bits, ages and the fill count; capacity resets to 16.
module lru_key_value_cache_unit import lkvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [0] mode, [32:1] key, [63:33] write_value
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [0] found, [32:1] read_value, [33] evicted,
                                       // [65:34] evicted_key, [71:66] zero
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cmd_t             cmd;
  logic [CAP_W-1:0] capacity;

  assign pready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Register read
  always_comb begin
    if (paddr[2] == REG_CAPACITY) prdata = {{(DATA_W - CAP_W){1'b0}}, capacity};
    else prdata = '0;
  end

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lkvc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .capacity (capacity),
    .out_data (m_tdata)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the LRU key/value cache: stream traffic, capacity changes, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int WATCHDOG   = 2000;
  localparam int SETTLE     = 8;
  localparam int POOL_SIZE  = 20;
  localparam int PHASE_LEN  = 150;

  // One result transaction of the cache
  typedef struct {
    logic              found;
    logic [RVAL_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } cache_result_t;

  // Tracks the cache contents and recency order, queues the expected results
  class cache_tracker;
    logic [CAP_W-1:0] capacity;
    logic [KEY_W-1:0] keys[ENTRIES];
    logic [VAL_W-1:0] values[ENTRIES];
    bit               valid[ENTRIES];
    int               age[ENTRIES];
    int               used;
    cache_result_t    pending_results[$];
    int               errors;

    function new();
      capacity = CAP_RESET;
      used     = 0;
      errors   = 0;
      foreach (valid[i]) begin
        valid[i]  = 0;
        age[i]    = 0;
        keys[i]   = '0;
        values[i] = '0;
      end
    endfunction

    function void set_register(logic idx, logic [DATA_W-1:0] data);
      if (idx == REG_CAPACITY) capacity = data[CAP_W-1:0];
    endfunction

    // Make slot s most recent; valid entries younger than limit age by one
    function void refresh(int s, int limit);
      for (int i = 0; i < ENTRIES; i++)
        if (i != s && valid[i] && age[i] < limit) age[i]++;
      age[s] = 0;
    endfunction

    function void note_request(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
      cache_result_t r;
      int hit;
      int slot;
      int lim;
      int oldest;
      int eff;
      r = '{found: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
      hit = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (valid[i] && keys[i] == key) hit = i;
      if (mode == MODE_GET) begin
        if (hit >= 0) begin
          r.found      = 1'b1;
          r.read_value = {1'b0, values[hit]};
          refresh(hit, age[hit]);
        end else begin
          r.read_value = '1;
        end
      end else if (hit >= 0) begin
        r.found     = 1'b1;
        values[hit] = wval;
        refresh(hit, age[hit]);
      end else begin
        eff    = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
        slot   = -1;
        oldest = 0;
        lim    = used;
        // Full: the least recent valid entry makes room
        if (used >= eff) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && (slot < 0 || age[i] > oldest)) begin
              slot   = i;
              oldest = age[i];
            end
          if (slot >= 0) begin
            r.evicted     = 1'b1;
            r.evicted_key = keys[slot];
            lim           = oldest;
          end
        end
        // Otherwise the lowest free entry
        if (slot < 0) begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!valid[i]) slot = i;
          if (slot < 0) slot = 0;
          if (!valid[slot]) used++;
        end
        keys[slot]   = key;
        values[slot] = wval;
        valid[slot]  = 1;
        refresh(slot, lim);
      end
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [OUT_W-1:0] d);
      cache_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, d);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (d[0] !== e.found) begin
        $display("%0t: found mismatch, expected %0b actual %0b", $time, e.found, d[0]);
        errors++;
      end
      if (d[32:1] !== e.read_value) begin
        $display("%0t: read_value mismatch, expected %h actual %h", $time, e.read_value,
                 d[32:1]);
        errors++;
      end
      if (d[33] !== e.evicted) begin
        $display("%0t: evicted mismatch, expected %0b actual %0b", $time, e.evicted, d[33]);
        errors++;
      end
      if (d[65:34] !== e.evicted_key) begin
        $display("%0t: evicted_key mismatch, expected %h actual %h", $time, e.evicted_key,
                 d[65:34]);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;   // [0] mode, [32:1] key, [63:33] write_value
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [OUT_W-1:0]  m_tdata;         // [0] found, [32:1] read_value, [33] evicted,
                                      // [65:34] evicted_key, [71:66] zero
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cache_tracker      tracker = new();
  logic [KEY_W-1:0]  key_pool[POOL_SIZE];
  bit                calm = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  lru_key_value_cache_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Result side backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_tready   = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_response(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // One get or set transaction, with an optional gap in front
  task automatic send_item(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata  = {$urandom(), $urandom()};
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {wval, key, mode};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(mode, key, wval);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
  endtask

  task automatic reg_write(logic idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Capacity change between phases, with the block idle
  task automatic set_capacity(logic [DATA_W-1:0] cap);
    drain();
    repeat (SETTLE) @(negedge clk);
    reg_write(REG_CAPACITY, cap);
  endtask

  // Random gets and sets, mostly over the first span keys of the pool
  task automatic random_phase(int count, int span, bit with_pause);
    logic             mode;
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      if ((with_pause && n == count / 2) || (!calm && $urandom_range(0, 199) == 0)) drain();
      mode = 1'($urandom_range(0, 1));
      key  = ($urandom_range(0, 6) == 0) ? $urandom() : key_pool[$urandom_range(0, span - 1)];
      send_item(mode, key, VAL_W'($urandom()));
    end
  endtask

  initial begin
    int unsigned caps[7];
    int          span;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    caps = '{4, 0, 31, 1, 2, $urandom_range(0, 31), $urandom_range(3, 15)};

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: empty miss, extreme keys and values, hit, update, fill and evict
    send_item(MODE_GET, 32'h0000_0000, 31'h0);
    send_item(MODE_SET, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(MODE_SET, 32'h7FFF_FFFF, 31'h0);
    send_item(MODE_SET, 32'h0000_0000, 31'h1);
    send_item(MODE_SET, 32'hFFFF_FFFF, 31'h5555_5555);
    send_item(MODE_GET, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(MODE_GET, 32'hFFFF_FFFF, 31'h0);
    send_item(MODE_GET, 32'h1234_5678, 31'h0);
    send_item(MODE_SET, 32'h0000_0000, 31'h2AAA_AAAA);
    send_item(MODE_GET, 32'h0000_0000, 31'h0);
    for (int i = 0; i < 13; i++) send_item(MODE_SET, 32'd100 + i, VAL_W'($urandom()));
    send_item(MODE_GET, 32'h7FFF_FFFF, 31'h0);

    // Random phases at default and lowered, zero, oversized and odd capacities
    random_phase(PHASE_LEN, POOL_SIZE, 1'b1);
    foreach (caps[p]) begin
      if (p == 3) begin
        drain();
        repeat (SETTLE) @(negedge clk);
        reg_write(~REG_CAPACITY, 32'd9);
      end
      set_capacity(caps[p]);
      span = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
      span = (span + 4 > POOL_SIZE) ? POOL_SIZE : span + 4;
      random_phase(PHASE_LEN - 30, span, 1'b0);
    end

    // Final stretch at full capacity with no idling
    set_capacity(DATA_W'(CAP_RESET));
    calm = 1;
    random_phase(PHASE_LEN - 50, POOL_SIZE, 1'b0);

    drain();
    repeat (SETTLE * 2) @(negedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
